@@ hw/rtl/rcl_pkg.sv @@
// Shared types, codes and sizes for the relay card command link.
// No dependencies; used by every module of the block.
package rcl_pkg;

   // Number of cards held in the port cache (addresses 1 to CARDS).
   localparam int CARDS      = 8;
   localparam int CARD_IDX_W = (CARDS > 1) ? $clog2(CARDS) : 1;

   // Input item operations
   localparam logic OP_COMMAND = 1'b0;
   localparam logic OP_RX_BYTE = 1'b1;

   // Result item kinds
   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Command codes that touch the port cache
   localparam logic [7:0] CMD_GET_PORT   = 8'd2;
   localparam logic [7:0] CMD_SET_PORT   = 8'd3;
   localparam logic [7:0] CMD_SET_BITS   = 8'd6;
   localparam logic [7:0] CMD_CLEAR_BITS = 8'd7;

   // The card echoes the command inverted
   localparam logic [7:0] ECHO_MASK = 8'hFF;

   // Reply status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_ECHO = 2'd1;
   localparam logic [1:0] ST_BAD_SUM  = 2'd2;

   // Command being served
   typedef struct packed {
      logic [7:0] cmd;
      logic [7:0] addr;
      logic [7:0] data;
   } pending_type;

   // Completed reply handed to the cache stage
   typedef struct packed {
      logic [7:0] cmd;
      logic [7:0] addr;
      logic [7:0] data;
      logic [7:0] reply2;
      logic [1:0] status;
   } check_type;

   // Completion report from the cache stage
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] reply_data;
      logic [7:0] cached_port;
   } report_type;

endpackage

@@ hw/rtl/rcl_front.sv @@
// Front end: pending command registers, reply byte collection and frame check.
// Depends on rcl_pkg.
module rcl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  logic                operation,
   input  logic [7:0]          command_code,
   input  logic [7:0]          card_address,
   input  logic [7:0]          data_byte,
   input  logic [7:0]          rx_byte,
   output rcl_pkg::pending_type pend,
   output logic                check_go,
   output rcl_pkg::check_type  check
);

   rcl_pkg::pending_type pend_ff;
   logic                 awaiting_ff;
   logic [1:0]           count_ff;
   logic [7:0]           reply_ff [3];
   logic                 is_cmd;
   logic                 is_rx;
   logic [1:0]           status_in;

   assign is_cmd   = in_accept && (operation == rcl_pkg::OP_COMMAND);
   assign is_rx    = in_accept && (operation == rcl_pkg::OP_RX_BYTE) && awaiting_ff;
   assign check_go = is_rx && (count_ff == 2'd3);
   assign pend     = pend_ff;

   // Frame check on the fourth byte; a bad echo wins over a bad checksum
   always_comb begin
      priority if (reply_ff[0] != (pend_ff.cmd ^ rcl_pkg::ECHO_MASK)) begin
         status_in = rcl_pkg::ST_BAD_ECHO;
      end else if ((reply_ff[0] ^ reply_ff[1] ^ reply_ff[2]) != rx_byte) begin
         status_in = rcl_pkg::ST_BAD_SUM;
      end else begin
         status_in = rcl_pkg::ST_OK;
      end
   end

   assign check.cmd    = pend_ff.cmd;
   assign check.addr   = pend_ff.addr;
   assign check.data   = pend_ff.data;
   assign check.reply2 = reply_ff[2];
   assign check.status = status_in;

   // Command and reply progress
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         awaiting_ff <= 1'b0;
         count_ff    <= 2'd0;
      end else if (is_cmd) begin
         pend_ff.cmd  <= command_code;
         pend_ff.addr <= card_address;
         pend_ff.data <= data_byte;
         awaiting_ff  <= 1'b1;
         count_ff     <= 2'd0;
      end else if (is_rx) begin
         if (count_ff == 2'd3) begin
            awaiting_ff <= 1'b0;
            count_ff    <= 2'd0;
         end else begin
            count_ff <= count_ff + 2'd1;
         end
      end
   end

   // First three reply bytes, no reset needed
   always_ff @(posedge clock) begin
      if (is_rx && (count_ff != 2'd3)) begin
         reply_ff[count_ff] <= rx_byte;
      end
   end

   a_count_needs_reply: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd0) |-> awaiting_ff)
      else $error("reply byte count set while no reply is awaited");

   a_cmd_restarts: assert property (@(posedge clock) disable iff (reset)
      is_cmd |=> (awaiting_ff && (count_ff == 2'd0)))
      else $error("command did not restart reply collection");

   a_check_closes: assert property (@(posedge clock) disable iff (reset)
      check_go |=> !awaiting_ff)
      else $error("reply still awaited after frame check");

endmodule

@@ hw/rtl/rcl_port_cache.sv @@
// Port cache: synchronous memory of relay states with read-modify-write stage.
// Depends on rcl_pkg.
module rcl_port_cache (
   input  logic                clock,
   input  logic                reset,
   input  logic                check_go,
   input  rcl_pkg::check_type  check,
   input  logic                advance,
   output logic                report_valid,
   output rcl_pkg::report_type report
);

   logic [7:0]                     mem [rcl_pkg::CARDS];
   logic [rcl_pkg::CARDS-1:0]      written_ff;
   logic [7:0]                     rd_data_ff;
   logic                           rd_written_ff;
   logic                           s1_valid_ff;
   rcl_pkg::check_type             s1_check_ff;
   logic                           s1_addr_ok_ff;
   logic [rcl_pkg::CARD_IDX_W-1:0] s1_idx_ff;
   logic                           addr_ok;
   logic [7:0]                     addr_m1;
   logic [rcl_pkg::CARD_IDX_W-1:0] rd_idx;
   logic [7:0]                     cur;
   logic [7:0]                     new_in;
   logic                           upd;
   logic                           wr_en;

   // Cards are numbered from one
   assign addr_ok = (check.addr != 8'd0) && (check.addr <= 8'(rcl_pkg::CARDS));
   assign addr_m1 = check.addr - 8'd1;
   assign rd_idx  = addr_m1[rcl_pkg::CARD_IDX_W-1:0];

   // Read port, registered
   always_ff @(posedge clock) begin
      if (check_go && addr_ok) begin
         rd_data_ff    <= mem[rd_idx];
         rd_written_ff <= written_ff[rd_idx];
      end
   end

   // Stage registers for the transaction being completed
   always_ff @(posedge clock) begin
      if (check_go) begin
         s1_check_ff   <= check;
         s1_addr_ok_ff <= addr_ok;
         s1_idx_ff     <= rd_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (check_go) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Unwritten entries read as zero
   assign cur = (s1_addr_ok_ff && rd_written_ff) ? rd_data_ff : 8'd0;

   // New relay state by command
   always_comb begin
      upd    = (s1_check_ff.status == rcl_pkg::ST_OK);
      new_in = cur;
      unique case (s1_check_ff.cmd)
         rcl_pkg::CMD_GET_PORT:   new_in = s1_check_ff.reply2;
         rcl_pkg::CMD_SET_PORT:   new_in = s1_check_ff.data;
         rcl_pkg::CMD_SET_BITS:   new_in = cur | s1_check_ff.data;
         rcl_pkg::CMD_CLEAR_BITS: new_in = cur & ~s1_check_ff.data;
         default:                 upd    = 1'b0;
      endcase
   end

   assign wr_en = s1_valid_ff && advance && upd && s1_addr_ok_ff;

   // Write back when the report leaves
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_idx_ff] <= new_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[s1_idx_ff] <= 1'b1;
      end
   end

   assign report_valid       = s1_valid_ff;
   assign report.status      = s1_check_ff.status;
   assign report.reply_data  = s1_check_ff.reply2;
   assign report.cached_port = !s1_addr_ok_ff ? 8'd0 : (upd ? new_in : cur);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      check_go |-> !s1_valid_ff)
      else $error("cache lookup issued while previous one still held");

   a_rw_apart: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !check_go)
      else $error("cache read and write in the same cycle");

   a_held_stable: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(report.cached_port)))
      else $error("held report changed");

endmodule

@@ hw/rtl/relay_card_command_link.sv @@
// Top level of the relay card command link: transmit sequencer and result register.
// Depends on rcl_pkg, rcl_front and rcl_port_cache.
//
// Usage:
// The req_ channel takes one transaction per item: a command (operation 0)
// or one received reply byte (operation 1). The rsp_ channel returns the
// result items from one output register, so the receiver may stall freely.
// A command gives four transmit bytes (command, address, data, XOR of the
// three), the fourth marked with rsp_last. Reply bytes are collected; the
// fourth one gives a single report with status, reply data and the cached
// relay state of the card. Reply bytes with no command outstanding give
// nothing.
// Order: a taken command loads the transmit sequencer, which feeds the output
// register; the fourth reply byte starts the cache read in its cycle, the cache
// stage holds the report, and write back happens as it enters the output register.
// Flow: a new command is taken only once the last transmit byte of the one before
// enters the single output register; reply bytes one per cycle while the sequencer
// is not busy; the fourth holds input off until the cache stage hands on the report.
// Reset clears the pending command, the reply state and the whole port cache
// at once (per-entry written flags). A stalled rsp_ channel holds the current
// result and, once the sequencer or cache stage is full, drops req_ready.
module relay_card_command_link (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_command_code,
   input  logic [7:0] req_card_address,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_kind,
   output logic [7:0] rsp_tx_byte,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_reply_data,
   output logic [7:0] rsp_cached_port,
   output logic       rsp_last
);

   rcl_pkg::pending_type pend;
   rcl_pkg::check_type   check;
   rcl_pkg::report_type  report;
   logic                 check_go;
   logic                 report_valid;
   logic                 advance;
   logic                 in_accept;
   logic                 out_free;
   logic                 is_cmd;
   logic [2:0]           tx_cnt_ff;
   logic [7:0]           tx_sel;
   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [7:0]           rsp_tx_byte_ff;
   logic [1:0]           rsp_status_ff;
   logic [7:0]           rsp_reply_data_ff;
   logic [7:0]           rsp_cached_port_ff;
   logic                 rsp_last_ff;

   // Handshake
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !report_valid &&
                      ((tx_cnt_ff == 3'd0) || ((tx_cnt_ff == 3'd1) && out_free));
   assign in_accept = req_valid && req_ready;
   assign is_cmd    = in_accept && (req_operation == rcl_pkg::OP_COMMAND);
   assign advance   = report_valid && out_free;

   rcl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .operation    (req_operation),
      .command_code (req_command_code),
      .card_address (req_card_address),
      .data_byte    (req_data_byte),
      .rx_byte      (req_rx_byte),
      .pend         (pend),
      .check_go     (check_go),
      .check        (check)
   );

   rcl_port_cache u_cache (
      .clock        (clock),
      .reset        (reset),
      .check_go     (check_go),
      .check        (check),
      .advance      (advance),
      .report_valid (report_valid),
      .report       (report)
   );

   // Transmit byte for the current sequencer count
   always_comb begin
      unique case (tx_cnt_ff)
         3'd4:    tx_sel = pend.cmd;
         3'd3:    tx_sel = pend.addr;
         3'd2:    tx_sel = pend.data;
         3'd1:    tx_sel = pend.cmd ^ pend.addr ^ pend.data;
         default: tx_sel = 8'd0;
      endcase
   end

   // Transmit sequencer and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_cnt_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= report_valid || (tx_cnt_ff != 3'd0);
         end
         if (is_cmd) begin
            tx_cnt_ff <= 3'd4;
         end else if (out_free && !report_valid && (tx_cnt_ff != 3'd0)) begin
            tx_cnt_ff <= tx_cnt_ff - 3'd1;
         end
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (report_valid) begin
            rsp_kind_ff        <= rcl_pkg::KIND_REPORT;
            rsp_tx_byte_ff     <= 8'd0;
            rsp_status_ff      <= report.status;
            rsp_reply_data_ff  <= report.reply_data;
            rsp_cached_port_ff <= report.cached_port;
            rsp_last_ff        <= 1'b1;
         end else begin
            rsp_kind_ff        <= rcl_pkg::KIND_TX;
            rsp_tx_byte_ff     <= tx_sel;
            rsp_status_ff      <= rcl_pkg::ST_OK;
            rsp_reply_data_ff  <= 8'd0;
            rsp_cached_port_ff <= 8'd0;
            rsp_last_ff        <= (tx_cnt_ff == 3'd1);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_tx_byte     = rsp_tx_byte_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_reply_data  = rsp_reply_data_ff;
   assign rsp_cached_port = rsp_cached_port_ff;
   assign rsp_last        = rsp_last_ff;

   a_report_alone: assert property (@(posedge clock) disable iff (reset)
      report_valid |-> (tx_cnt_ff == 3'd0))
      else $error("report pending while transmit bytes remain");

   a_cmd_loads_seq: assert property (@(posedge clock) disable iff (reset)
      is_cmd |=> (tx_cnt_ff == 3'd4))
      else $error("command did not load the transmit sequencer");

   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      tx_cnt_ff <= 3'd4)
      else $error("transmit sequencer out of range");

endmodule

@@ tb/sv/relay_link_checker.sv @@
`timescale 1ns / 100ps
// Response checker for the relay card command link: predicts transmit bytes and
// reply reports from accepted request transactions and compares every response.
// Depends on rcl_pkg for the operation, kind, command, echo and status codes.
module relay_link_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_operation,
   input  logic [7:0] req_command_code,
   input  logic [7:0] req_card_address,
   input  logic [7:0] req_data_byte,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_kind,
   input  logic [7:0] rsp_tx_byte,
   input  logic [1:0] rsp_status,
   input  logic [7:0] rsp_reply_data,
   input  logic [7:0] rsp_cached_port,
   input  logic       rsp_last,
   output int         failures,
   output int         outstanding,
   output int         tx_checked,
   output int         reports_checked,
   output int         reports_ok
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic       kind;
      logic [7:0] tx_byte;
      logic [1:0] status;
      logic [7:0] reply_data;
      logic [7:0] cached_port;
      logic       last;
   } link_result_type;

   // Shadow of the link state
   logic [7:0]   sent_cmd;
   logic [7:0]   sent_addr;
   logic [7:0]   sent_data;
   int           frame_len;
   logic [7:0]   frame_bytes [0:2];
   bit           frame_open;
   logic [7:0]   relay_state [1:rcl_pkg::CARDS];

   link_result_type expected_link_items [$];
   int           mismatch_count;
   int           tx_count;
   int           report_count;
   int           ok_count;

   function automatic bit card_in_range(input logic [7:0] addr);
      return addr >= 1 && addr <= rcl_pkg::CARDS;
   endfunction

   function automatic link_result_type tx_result(input logic [7:0] b, input logic is_last);
      link_result_type r;
      r = '0;
      r.kind = rcl_pkg::KIND_TX;
      r.tx_byte = b;
      r.last = is_last;
      return r;
   endfunction

   // Work out the results of one request transaction and queue them
   task automatic predict_link_results(input logic op, input logic [7:0] cmd,
                                       input logic [7:0] addr, input logic [7:0] data,
                                       input logic [7:0] rx);
      link_result_type r;
      logic [1:0]   st;
      logic [7:0]   cur;
      if (op == rcl_pkg::OP_COMMAND) begin
         sent_cmd = cmd;
         sent_addr = addr;
         sent_data = data;
         frame_len = 0;
         frame_open = 1'b1;
         expected_link_items.push_back(tx_result(cmd, 1'b0));
         expected_link_items.push_back(tx_result(addr, 1'b0));
         expected_link_items.push_back(tx_result(data, 1'b0));
         expected_link_items.push_back(tx_result(cmd ^ addr ^ data, 1'b1));
      end else if (frame_open) begin
         if (frame_len < 3) begin
            frame_bytes[frame_len] = rx;
            frame_len++;
         end else begin
            // fourth byte closes the frame: echo first, then checksum
            if (frame_bytes[0] != (sent_cmd ^ rcl_pkg::ECHO_MASK))
               st = rcl_pkg::ST_BAD_ECHO;
            else if ((frame_bytes[0] ^ frame_bytes[1] ^ frame_bytes[2]) != rx)
               st = rcl_pkg::ST_BAD_SUM;
            else
               st = rcl_pkg::ST_OK;
            if (st == rcl_pkg::ST_OK && card_in_range(sent_addr)) begin
               cur = relay_state[sent_addr];
               case (sent_cmd)
                  rcl_pkg::CMD_GET_PORT:   relay_state[sent_addr] = frame_bytes[2];
                  rcl_pkg::CMD_SET_PORT:   relay_state[sent_addr] = sent_data;
                  rcl_pkg::CMD_SET_BITS:   relay_state[sent_addr] = cur | sent_data;
                  rcl_pkg::CMD_CLEAR_BITS: relay_state[sent_addr] = cur & ~sent_data;
                  default: ;
               endcase
            end
            r = '0;
            r.kind = rcl_pkg::KIND_REPORT;
            r.status = st;
            r.reply_data = frame_bytes[2];
            r.cached_port = card_in_range(sent_addr) ? relay_state[sent_addr] : 8'h00;
            r.last = 1'b1;
            expected_link_items.push_back(r);
            frame_len = 0;
            frame_open = 1'b0;
         end
      end
      // reply byte with no command outstanding: nothing expected
   endtask

   // Sample both channels at the clock edge
   always @(posedge clock) begin : watch
      link_result_type seen;
      link_result_type want;
      if (reset) begin
         sent_cmd = '0;
         sent_addr = '0;
         sent_data = '0;
         frame_len = 0;
         frame_open = 1'b0;
         foreach (relay_state[i])
            relay_state[i] = '0;
         expected_link_items.delete();
      end else begin
         if (req_valid && req_ready)
            predict_link_results(req_operation, req_command_code, req_card_address,
                                 req_data_byte, req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_kind, rsp_tx_byte, rsp_status, rsp_reply_data,
                    rsp_cached_port, rsp_last};
            if (seen.kind == rcl_pkg::KIND_REPORT) begin
               report_count++;
               if (seen.status == rcl_pkg::ST_OK)
                  ok_count++;
            end else begin
               tx_count++;
            end
            if (expected_link_items.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result with nothing pending: kind %0d tx %02h st %0d",
                           $realtime, seen.kind, seen.tx_byte, seen.status);
            end else begin
               want = expected_link_items.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch, expected kind %0d tx %02h st %0d data %02h",
                              $realtime, want.kind, want.tx_byte, want.status,
                              want.reply_data);
                     $display("   port %02h last %0d; got kind %0d tx %02h st %0d",
                              want.cached_port, want.last, seen.kind, seen.tx_byte,
                              seen.status);
                     $display("   data %02h port %02h last %0d",
                              seen.reply_data, seen.cached_port, seen.last);
                  end
               end
            end
         end
      end
      failures <= mismatch_count;
      outstanding <= expected_link_items.size();
      tx_checked <= tx_count;
      reports_checked <= report_count;
      reports_ok <= ok_count;
   end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the relay card command link: clock, reset, request and
// response stimulus, watchdog and verdict. Depends on rcl_pkg,
// relay_card_command_link and relay_link_checker.
module tb;

   localparam int   RESET_CYCLES = 6;
   localparam int   TOTAL_ITEMS  = 160;
   localparam int   LONG_HOLD    = 150;
   localparam int   STALL_LIMIT  = 1000;
   localparam int   SETTLE       = 8;
   localparam logic [7:0] PLAIN_CMD = 8'h00;

   typedef enum {REPLY_GOOD, REPLY_BAD_ECHO, REPLY_BAD_SUM, REPLY_BAD_BOTH} reply_fault_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_operation;
   logic [7:0] req_command_code;
   logic [7:0] req_card_address;
   logic [7:0] req_data_byte;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_kind;
   logic [7:0] rsp_tx_byte;
   logic [1:0] rsp_status;
   logic [7:0] rsp_reply_data;
   logic [7:0] rsp_cached_port;
   logic       rsp_last;

   int failures;
   int outstanding;
   int tx_checked;
   int reports_checked;
   int reports_ok;

   int counted_items;
   int requests_sent;
   int replies_due;
   bit tail_phase;
   bit burst_mode;
   bit hold_off_request;

   relay_card_command_link DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_command_code (req_command_code),
      .req_card_address (req_card_address),
      .req_data_byte    (req_data_byte),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_status       (rsp_status),
      .rsp_reply_data   (rsp_reply_data),
      .rsp_cached_port  (rsp_cached_port),
      .rsp_last         (rsp_last)
   );

   relay_link_checker link_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_command_code (req_command_code),
      .req_card_address (req_card_address),
      .req_data_byte    (req_data_byte),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_status       (rsp_status),
      .rsp_reply_data   (rsp_reply_data),
      .rsp_cached_port  (rsp_cached_port),
      .rsp_last         (rsp_last),
      .failures         (failures),
      .outstanding      (outstanding),
      .tx_checked       (tx_checked),
      .reports_checked  (reports_checked),
      .reports_ok       (reports_ok)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Mostly cache commands, now and then any code
   function automatic logic [7:0] pick_command();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1:    c = rcl_pkg::CMD_GET_PORT;
         2, 3:    c = rcl_pkg::CMD_SET_PORT;
         4, 5:    c = rcl_pkg::CMD_SET_BITS;
         6, 7:    c = rcl_pkg::CMD_CLEAR_BITS;
         default: c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // Mostly cached cards and their neighbours, now and then any address
   function automatic logic [7:0] pick_address();
      logic [7:0] a;
      if ($urandom_range(0, 5) == 0)
         a = 8'($urandom_range(0, 255));
      else
         a = 8'($urandom_range(0, rcl_pkg::CARDS + 1));
      return a;
   endfunction

   // Present one request transaction and hold it until it is taken
   task automatic offer_item(input logic op, input logic [7:0] cmd, input logic [7:0] addr,
                             input logic [7:0] data, input logic [7:0] rx);
      if (!tail_phase && !burst_mode && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_command_code <= cmd;
      req_card_address <= addr;
      req_data_byte <= data;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_command(input logic [7:0] cmd, input logic [7:0] addr,
                               input logic [7:0] data);
      offer_item(rcl_pkg::OP_COMMAND, cmd, addr, data, 8'($urandom_range(0, 255)));
      counted_items++;
      replies_due = 4;
   endtask

   // Reply bytes only count while a frame is open
   task automatic send_rx(input logic [7:0] b);
      offer_item(rcl_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), b);
      if (replies_due > 0) begin
         counted_items++;
         replies_due--;
      end
   endtask

   // Four-byte reply frame: echo, free byte, reply data, checksum
   task automatic send_reply(input logic [7:0] cmd, input logic [7:0] payload,
                             input reply_fault_type fault);
      logic [7:0] echo;
      logic [7:0] second;
      logic [7:0] sum;
      logic [7:0] flip;
      echo = cmd ^ rcl_pkg::ECHO_MASK;
      second = 8'($urandom_range(0, 255));
      flip = 8'($urandom_range(1, 255));
      if (fault == REPLY_BAD_ECHO || fault == REPLY_BAD_BOTH)
         echo = echo ^ flip;
      sum = echo ^ second ^ payload;
      flip = 8'($urandom_range(1, 255));
      if (fault == REPLY_BAD_SUM || fault == REPLY_BAD_BOTH)
         sum = sum ^ flip;
      send_rx(echo);
      send_rx(second);
      send_rx(payload);
      send_rx(sum);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts, one long hold-off on request, none at the tail
   initial begin : receiver
      rsp_ready <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (tail_phase) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Stimulus and verdict
   initial begin : stimulus
      logic [7:0]   cmd;
      logic [7:0]   addr;
      logic [7:0]   data;
      int           pick;
      bit           pressure_done;
      bit           drain_done;
      reply_fault_type fault;

      counted_items = 0;
      requests_sent = 0;
      replies_due = 0;
      tail_phase = 1'b0;
      burst_mode = 1'b0;
      hold_off_request = 1'b0;
      pressure_done = 1'b0;
      drain_done = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= rcl_pkg::OP_COMMAND;
      req_command_code <= '0;
      req_card_address <= '0;
      req_data_byte <= '0;
      req_rx_byte <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: stray reply byte while idle
      send_rx(8'hFF);
      // highest card: set all relays, then clear the low nibble
      send_command(rcl_pkg::CMD_SET_PORT, 8'(rcl_pkg::CARDS), 8'hFF);
      send_reply(rcl_pkg::CMD_SET_PORT, 8'h00, REPLY_GOOD);
      send_command(rcl_pkg::CMD_CLEAR_BITS, 8'(rcl_pkg::CARDS), 8'h0F);
      send_reply(rcl_pkg::CMD_CLEAR_BITS, 8'hFF, REPLY_GOOD);
      // address zero reads as 0 and is never written
      send_command(rcl_pkg::CMD_GET_PORT, 8'h00, 8'h00);
      send_reply(rcl_pkg::CMD_GET_PORT, 8'h55, REPLY_GOOD);
      // top address with echo and checksum both wrong
      send_command(rcl_pkg::CMD_SET_BITS, 8'hFF, 8'hFF);
      send_reply(rcl_pkg::CMD_SET_BITS, 8'hAA, REPLY_BAD_BOTH);
      // plain command abandoned half way by a fresh get-port
      send_command(PLAIN_CMD, 8'h01, 8'h80);
      send_rx(8'hFF);
      send_rx(8'h00);
      send_command(rcl_pkg::CMD_GET_PORT, 8'h01, 8'h00);
      send_reply(rcl_pkg::CMD_GET_PORT, 8'h3C, REPLY_GOOD);
      wait_drained();

      // Random: mostly whole frames, some broken frames and stray bytes
      while (counted_items < TOTAL_ITEMS) begin
         if (!pressure_done && counted_items >= 70) begin
            // back-to-back commands against a receiver on long hold
            pressure_done = 1'b1;
            hold_off_request = 1'b1;
            burst_mode = 1'b1;
            repeat (6) send_command(pick_command(), pick_address(),
                                    8'($urandom_range(0, 255)));
            burst_mode = 1'b0;
         end
         if (!drain_done && counted_items >= 110) begin
            drain_done = 1'b1;
            wait_drained();
         end
         tail_phase = counted_items >= 135;
         cmd = pick_command();
         addr = pick_address();
         data = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            send_command(cmd, addr, data);
            pick = $urandom_range(0, 19);
            if (pick < 14)
               fault = REPLY_GOOD;
            else if (pick < 16)
               fault = REPLY_BAD_ECHO;
            else if (pick < 18)
               fault = REPLY_BAD_SUM;
            else
               fault = REPLY_BAD_BOTH;
            send_reply(cmd, 8'($urandom_range(0, 255)), fault);
         end else if (pick < 17) begin
            send_command(cmd, addr, data);
            repeat ($urandom_range(0, 3)) send_rx(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 3)) send_rx(8'($urandom_range(0, 255)));
         end
      end

      // Drain and let any stray result show up
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d request transactions: %0d transmit bytes and %0d reply reports,",
               requests_sent, tx_checked, reports_checked);
      $display("%0d reports ok, the rest refused on echo or checksum; %0d failures",
               reports_ok, failures);
      if (failures == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/rcl_pkg.sv
hw/rtl/rcl_front.sv
hw/rtl/rcl_port_cache.sv
hw/rtl/relay_card_command_link.sv
tb/sv/relay_link_checker.sv
tb/sv/tb.sv
